>>> rtl/fs_metadata_crc32c_defines.svh
// Assertion macros shared by the checksum block.
`ifndef FS_METADATA_CRC32C_DEFINES_SVH
`define FS_METADATA_CRC32C_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, held off while reset is low.
`define FSMC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fsmc assertion failed");

// Next-cycle implication, held off while reset is low.
`define FSMC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fsmc assertion failed");

`else

`define FSMC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define FSMC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/fsmc_pkg.sv
package fsmc_pkg;

    localparam int LEN_W                    = 17;
    localparam int DEF_MAX_RECORD_BYTES     = 65536;

    localparam logic [31:0] CRC_POLY        = 32'h82F6_3B78;
    localparam logic [31:0] CRC_INIT        = 32'hFFFF_FFFF;
    localparam logic [31:0] GROUP_MASK      = 32'h0000_FFFF;

    // record kinds
    localparam logic [2:0] KIND_SUPER       = 3'd0;
    localparam logic [2:0] KIND_GROUP       = 3'd1;
    localparam logic [2:0] KIND_BITMAP      = 3'd2;
    localparam logic [2:0] KIND_INODE       = 3'd3;
    localparam logic [2:0] KIND_DIR         = 3'd4;
    localparam logic [2:0] KIND_EXTENT      = 3'd5;

    // configuration register indexes
    localparam logic REG_UUID_LOW           = 1'b0;
    localparam logic REG_UUID_HIGH          = 1'b1;

    // program step addresses
    localparam int STEP_W                   = 5;
    localparam logic [STEP_W-1:0] STEP_IDLE      = 5'd0;
    localparam logic [STEP_W-1:0] STEP_UUID0     = 5'd1;
    localparam logic [STEP_W-1:0] STEP_UUID_LAST = 5'd16;
    localparam logic [STEP_W-1:0] STEP_NUM0      = 5'd17;
    localparam logic [STEP_W-1:0] STEP_NUM_LAST  = 5'd20;
    localparam logic [STEP_W-1:0] STEP_GEN0      = 5'd21;
    localparam logic [STEP_W-1:0] STEP_GEN_LAST  = 5'd24;
    localparam logic [STEP_W-1:0] STEP_DATA      = 5'd25;

    typedef enum logic [4:0] {
        OP_IDLE = 5'b00001,
        OP_UUID = 5'b00010,
        OP_NUM  = 5'b00100,
        OP_GEN  = 5'b01000,
        OP_DATA = 5'b10000
    } t_op;

    typedef enum logic [1:0] {
        JC_NONE   = 2'd0,
        JC_NO_NUM = 2'd1,
        JC_NO_GEN = 2'd2
    } t_jcond;

    typedef struct packed {
        t_op               op;
        logic [3:0]        sel;
        t_jcond            jcond;
        logic [STEP_W-1:0] jtarget;
    } t_ctrl;

    typedef struct packed {
        logic start;
        logic start_super;
        logic defer;
        logic no_num;
        logic no_gen;
        logic hold;
    } t_seq_stat;

    typedef struct packed {
        logic        valid;
        logic [31:0] checksum;
    } t_emit;

    // one byte through the reflected CRC32C register
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] v;
        v = c ^ {24'h0, b};
        for (int i = 0; i < 8; i++) begin
            v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
        end
        return v;
    endfunction

    // control store
    function automatic t_ctrl ucode_word(input logic [STEP_W-1:0] step);
        t_ctrl w;
        w = '{op: OP_IDLE, sel: 4'd0, jcond: JC_NONE, jtarget: STEP_IDLE};
        case (step) inside
            STEP_IDLE: begin
                w.op = OP_IDLE;
            end
            [STEP_UUID0:STEP_UUID_LAST]: begin
                w.op  = OP_UUID;
                w.sel = 4'(step - STEP_UUID0);
                if (step == STEP_UUID_LAST) begin
                    w.jcond   = JC_NO_NUM;
                    w.jtarget = STEP_DATA;
                end
            end
            [STEP_NUM0:STEP_NUM_LAST]: begin
                w.op  = OP_NUM;
                w.sel = 4'(step - STEP_NUM0);
                if (step == STEP_NUM_LAST) begin
                    w.jcond   = JC_NO_GEN;
                    w.jtarget = STEP_DATA;
                end
            end
            [STEP_GEN0:STEP_GEN_LAST]: begin
                w.op  = OP_GEN;
                w.sel = 4'(step - STEP_GEN0);
            end
            STEP_DATA: begin
                w.op = OP_DATA;
            end
            default: begin
                w.op = OP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

>>> rtl/fsmc_sequencer.sv
module fsmc_sequencer import fsmc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_seq_stat i_stat,
    output t_ctrl     o_ctrl
);

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_ctrl             ctrl;
    logic              jump;

    assign ctrl   = ucode_word(r_step);
    assign o_ctrl = ctrl;

    always_comb begin
        case (ctrl.jcond)
            JC_NO_NUM: jump = i_stat.no_num;
            JC_NO_GEN: jump = i_stat.no_gen;
            default:   jump = 1'b0;
        endcase
    end

    always_comb begin
        n_step = r_step + 1'b1;
        case (ctrl.op)
            OP_IDLE: begin
                if (i_stat.start) begin
                    n_step = i_stat.start_super ? STEP_DATA : STEP_UUID0;
                end else if (i_stat.defer) begin
                    n_step = STEP_DATA;
                end else begin
                    n_step = STEP_IDLE;
                end
            end
            OP_DATA: begin
                n_step = i_stat.hold ? STEP_DATA : STEP_IDLE;
            end
            default: begin
                if (jump) begin
                    n_step = ctrl.jtarget;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

>>> rtl/fsmc_datapath.sv
module fsmc_datapath import fsmc_pkg::*; #(
    parameter int MAX_RECORD_BYTES = DEF_MAX_RECORD_BYTES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_ctrl            i_ctrl,
    input  logic             i_accept,
    input  logic             i_first,
    input  logic [7:0]       i_byte,
    input  logic [2:0]       i_kind,
    input  logic [LEN_W-1:0] i_len,
    input  logic [31:0]      i_num,
    input  logic [31:0]      i_gen,
    input  logic             i_out_blocked,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [63:0]      i_cfg_wdata,
    output t_seq_stat        o_stat,
    output t_emit            o_emit
);

    localparam int PW = $clog2(MAX_RECORD_BYTES + 1);

    logic [63:0]      r_uuid_low;
    logic [63:0]      r_uuid_high;
    logic [31:0]      r_crc;
    logic [PW-1:0]    r_pos;
    logic [PW-1:0]    r_len;
    logic [2:0]       r_kind;
    logic [31:0]      r_num;
    logic [31:0]      r_gen;
    logic [7:0]       r_byte;
    logic [PW-1:0]    r_ext_limit;

    logic [2:0]       kind_in;
    logic [LEN_W-1:0] len_clamp;
    logic [PW-1:0]    pos_inc;
    logic             in_progress;
    logic             last;
    logic             is_data;
    logic             start;
    logic             idle_byte;
    logic             defer;
    logic             hold;
    logic             proc;
    logic             prefix;
    logic [7:0]       rule_in;
    logic [7:0]       rule_byte;
    logic             feed;
    logic [127:0]     uuid_all;
    logic [7:0]       pre_byte;
    logic [7:0]       op_byte;
    logic [31:0]      crc_step;
    logic [31:0]      crc_proc;
    logic [LEN_W-1:0] len_ext;
    logic [30:0]      ext_prod;
    logic [13:0]      ext_q;
    logic [LEN_W-1:0] ext_lim;

    // unused kinds behave as superblock; length clamped to 1..max
    assign kind_in = (i_kind > KIND_EXTENT) ? KIND_SUPER : i_kind;

    always_comb begin
        len_clamp = i_len;
        if (i_len == '0) begin
            len_clamp = LEN_W'(1);
        end else if (i_len > LEN_W'(MAX_RECORD_BYTES)) begin
            len_clamp = LEN_W'(MAX_RECORD_BYTES);
        end
    end

    assign pos_inc     = PW'(r_pos + 1'b1);
    assign in_progress = r_pos < r_len;
    assign last        = pos_inc >= r_len;
    assign is_data     = i_ctrl.op == OP_DATA;
    assign prefix      = (i_ctrl.op == OP_UUID) || (i_ctrl.op == OP_NUM)
                         || (i_ctrl.op == OP_GEN);
    assign start       = i_accept && i_first;
    assign idle_byte   = i_accept && !i_first && in_progress;
    assign defer       = idle_byte && last && i_out_blocked;
    assign hold        = is_data && last && i_out_blocked;
    assign proc        = (idle_byte && !defer) || (is_data && !hold);

    // extent limit: 12 * floor(len / 12) = 12 * floor(floor(len / 4) / 3)
    assign len_ext  = LEN_W'(r_len);
    assign ext_prod = 31'(len_ext[LEN_W-1:2]) * 31'd43691;
    assign ext_q    = ext_prod[30:17];
    assign ext_lim  = (LEN_W'(ext_q) << 3) + (LEN_W'(ext_q) << 2);

    // kind rules
    assign rule_in = is_data ? r_byte : i_byte;

    always_comb begin
        rule_byte = rule_in;
        feed      = 1'b1;
        case (r_kind)
            KIND_GROUP: begin
                if (r_pos == PW'(30) || r_pos == PW'(31)) begin
                    rule_byte = 8'h00;
                end else if (r_pos >= PW'(64)) begin
                    feed = 1'b0;
                end
            end
            KIND_INODE: begin
                if (r_pos == PW'(124) || r_pos == PW'(125)
                    || r_pos == PW'(130) || r_pos == PW'(131)) begin
                    rule_byte = 8'h00;
                end else if (r_pos >= PW'(256)) begin
                    feed = 1'b0;
                end
            end
            KIND_DIR: begin
                feed = (r_len > PW'(12)) && (r_pos < PW'(r_len - PW'(12)));
            end
            KIND_EXTENT: begin
                feed = r_pos < r_ext_limit;
            end
            default: begin
                feed = 1'b1;
            end
        endcase
    end

    assign uuid_all = {r_uuid_high, r_uuid_low};

    always_comb begin
        case (i_ctrl.op)
            OP_UUID: pre_byte = uuid_all[{i_ctrl.sel, 3'b000} +: 8];
            OP_NUM:  pre_byte = r_num[{i_ctrl.sel[1:0], 3'b000} +: 8];
            OP_GEN:  pre_byte = r_gen[{i_ctrl.sel[1:0], 3'b000} +: 8];
            default: pre_byte = 8'h00;
        endcase
    end

    assign op_byte  = prefix ? pre_byte : rule_byte;
    assign crc_step = crc_byte(r_crc, op_byte);
    assign crc_proc = feed ? crc_step : r_crc;

    assign o_stat.start       = start;
    assign o_stat.start_super = kind_in == KIND_SUPER;
    assign o_stat.defer       = defer;
    assign o_stat.no_num      = r_kind == KIND_BITMAP;
    assign o_stat.no_gen      = (r_kind == KIND_BITMAP) || (r_kind == KIND_GROUP);
    assign o_stat.hold        = hold;

    assign o_emit.valid    = proc && last;
    assign o_emit.checksum = (r_kind == KIND_GROUP) ? (crc_proc & GROUP_MASK) : crc_proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uuid_low  <= '0;
            r_uuid_high <= '0;
            r_crc       <= CRC_INIT;
            r_pos       <= '0;
            r_len       <= '0;
            r_kind      <= KIND_SUPER;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_UUID_LOW:  r_uuid_low  <= i_cfg_wdata;
                    REG_UUID_HIGH: r_uuid_high <= i_cfg_wdata;
                    default:       r_uuid_low  <= r_uuid_low;
                endcase
            end
            if (start) begin
                r_crc  <= CRC_INIT;
                r_pos  <= '0;
                r_len  <= PW'(len_clamp);
                r_kind <= kind_in;
            end else if (prefix) begin
                r_crc <= crc_step;
            end else if (proc) begin
                r_crc <= crc_proc;
                r_pos <= pos_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ext_limit <= PW'(ext_lim);
        if (i_accept) begin
            r_byte <= i_byte;
        end
        if (start) begin
            r_num <= i_num;
            r_gen <= i_gen;
        end
    end

endmodule

>>> rtl/fs_metadata_crc32c.sv
// Metadata record checksum engine (CRC32C, reflected, no final inversion).
// Input stream: one record byte per transaction. tuser bit 0 flags the
// first byte; on that byte kind, length, number and generation are sampled
// from tuser/tdata. Output stream: one checksum transaction per record,
// issued when the record's last byte has been processed.
// Configuration: write enable, index (0 UUID low, 1 UUID high) and 64-bit
// data; write only while the block is idle.
// Flow: a byte inside a record is folded in the idle step as it is accepted.
// A first byte is folded in the data step, and no byte is taken until that
// step is done. For all kinds but superblocks, a microcode prefix first folds
// one UUID/number/generation byte per step through the single byte-wide CRC
// unit: UUID; then number unless bitmap; then generation unless bitmap or group.
// Latency: the checksum is registered; it appears the cycle after the
// last byte is processed.
// Reset: synchronous, active low; UUID cleared, no record in progress.
// Stall: the output holds one checksum. A last byte that meets a full,
// stalled output waits in the data step; other bytes keep flowing.
module fs_metadata_crc32c import fsmc_pkg::*; #(
    parameter int MAX_RECORD_BYTES = DEF_MAX_RECORD_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // data_byte[7:0], record_length[24:8], record_number[56:25],
    // record_generation[88:57], zero pad[95:89]
    input  logic [95:0] s_axis_tdata,
    // first_of_record[0], record_kind[3:1]
    input  logic [3:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // checksum[31:0]
    output logic [31:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [63:0] i_cfg_wdata
);

`include "fs_metadata_crc32c_defines.svh"

    t_ctrl       ctrl;
    t_seq_stat   stat;
    t_emit       emit;
    logic        accept;
    logic        out_blocked;
    logic        r_out_valid;
    logic [31:0] r_out_data;

    // input is taken only in the idle step of the program
    assign s_axis_tready = ctrl.op == OP_IDLE;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_blocked   = r_out_valid && !m_axis_tready;

    fsmc_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    fsmc_datapath #(
        .MAX_RECORD_BYTES (MAX_RECORD_BYTES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ctrl),
        .i_accept      (accept),
        .i_first       (s_axis_tuser[0]),
        .i_byte        (s_axis_tdata[7:0]),
        .i_kind        (s_axis_tuser[3:1]),
        .i_len         (s_axis_tdata[24:8]),
        .i_num         (s_axis_tdata[56:25]),
        .i_gen         (s_axis_tdata[88:57]),
        .i_out_blocked (out_blocked),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_stat        (stat),
        .o_emit        (emit)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit.valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit.valid) begin
            r_out_data <= emit.checksum;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // a new checksum never overwrites one still waiting
    `FSMC_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, emit.valid, !out_blocked)
    // a non-superblock record start always enters the UUID prefix
    `FSMC_ASSERT_NXT(a_prefix_entry, i_clk, i_rst_n,
        accept && s_axis_tuser[0] && s_axis_tuser[3:1] != KIND_SUPER
        && s_axis_tuser[3:1] <= KIND_EXTENT, ctrl.op == OP_UUID)
    // prefix steps fold no record bytes and produce no checksum
    `FSMC_ASSERT_IMP(a_prefix_quiet, i_clk, i_rst_n,
        ctrl.op == OP_UUID || ctrl.op == OP_NUM || ctrl.op == OP_GEN, !emit.valid)

endmodule

>>> tb/fs_metadata_crc32c_tb.sv
module fs_metadata_crc32c_tb;
    import fsmc_pkg::*;

    localparam int MAX_BYTES   = DEF_MAX_RECORD_BYTES;
    localparam int LIMIT       = 1_000_000;  // cycles after reset release
    localparam int SETTLE      = 40;         // longest prefix plus output register, padded
    localparam int HOLD_CYCLES = 300;        // long receiver hold-off to back the block up

    // kinds the block has no rule for; treated as superblock
    localparam logic [2:0] KIND_SPARE6 = 3'd6;
    localparam logic [2:0] KIND_SPARE7 = 3'd7;

    typedef struct packed {
        logic        first;
        logic [2:0]  kind;
        logic [16:0] len;
        logic [31:0] num;
        logic [31:0] gen;
        logic [7:0]  data;
    } rec_byte_t;

    typedef struct packed {
        rec_byte_t   item;
        logic        known;  // sum typed in by hand rather than taken from the predictor
        logic [31:0] sum;
    } plan_row_t;

    // Directed opening, UUID still at its reset value of zero.
    // A lone 0xFF byte from an all-ones register shifts out to 0x00FFFFFF.
    localparam plan_row_t DIRECTED [20] = '{
        // stray byte, nothing in progress: ignored
        '{'{1'b0, KIND_SUPER,  17'd0,       32'd0,         32'd0,         8'h5A}, 1'b0, 32'd0},
        '{'{1'b1, KIND_SUPER,  17'd1,       32'd0,         32'd0,         8'hFF}, 1'b1,
          32'h00FF_FFFF},
        // zero length behaves as one byte
        '{'{1'b1, KIND_SUPER,  17'd0,       32'd0,         32'd0,         8'hFF}, 1'b1,
          32'h00FF_FFFF},
        // unused kind falls back to superblock handling
        '{'{1'b1, KIND_SPARE7, 17'd1,       32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF}, 1'b1,
          32'h00FF_FFFF},
        '{'{1'b1, KIND_SPARE6, 17'd2,       32'd0,         32'd0,         8'h00}, 1'b0, 32'd0},
        '{'{1'b0, KIND_SUPER,  17'd0,       32'd0,         32'd0,         8'hFF}, 1'b0, 32'd0},
        '{'{1'b1, KIND_GROUP,  17'd1,       32'hFFFF_FFFF, 32'd0,         8'hFF}, 1'b0, 32'd0},
        '{'{1'b1, KIND_BITMAP, 17'd2,       32'd0,         32'd0,         8'h00}, 1'b0, 32'd0},
        '{'{1'b0, KIND_SUPER,  17'd0,       32'd0,         32'd0,         8'h80}, 1'b0, 32'd0},
        '{'{1'b1, KIND_INODE,  17'd1,       32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h01}, 1'b0, 32'd0},
        // directory no longer than its tail: no record byte folded
        '{'{1'b1, KIND_DIR,    17'd1,       32'd0,         32'd0,         8'hFF}, 1'b0, 32'd0},
        '{'{1'b1, KIND_EXTENT, 17'd1,       32'h1234_5678, 32'h9ABC_DEF0, 8'h7F}, 1'b0, 32'd0},
        // over-long length, clamped, then abandoned by the next first byte
        '{'{1'b1, KIND_BITMAP, 17'h1_FFFF,  32'd0,         32'd0,         8'h3C}, 1'b0, 32'd0},
        '{'{1'b0, KIND_SUPER,  17'd0,       32'd0,         32'd0,         8'hAA}, 1'b0, 32'd0},
        '{'{1'b1, KIND_GROUP,  17'd2,       32'hA5A5_0F0F, 32'd0,         8'h55}, 1'b0, 32'd0},
        '{'{1'b0, KIND_SPARE7, 17'h1_FFFF,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hC3}, 1'b0, 32'd0},
        '{'{1'b1, KIND_EXTENT, 17'd2,       32'd7,         32'd9,         8'h11}, 1'b0, 32'd0},
        '{'{1'b0, KIND_SUPER,  17'd0,       32'd0,         32'd0,         8'h22}, 1'b0, 32'd0},
        // stray byte after a finished record
        '{'{1'b0, KIND_INODE,  17'd5,       32'd3,         32'd4,         8'hFF}, 1'b0, 32'd0},
        '{'{1'b1, KIND_INODE,  17'd1,       32'd0,         32'd0,         8'h00}, 1'b0, 32'd0}
    };

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // data_byte[7:0], record_length[24:8], record_number[56:25],
    // record_generation[88:57], zero pad[95:89]
    logic [95:0] s_axis_tdata  = '0;
    // first_of_record[0], record_kind[3:1]
    logic [3:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // checksum[31:0]
    logic [31:0] m_axis_tdata;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_idx     = REG_UUID_LOW;
    logic [63:0] i_cfg_wdata   = '0;

    // predictor copy of the block's registers
    logic [63:0] uuid_lo_m = '0;
    logic [63:0] uuid_hi_m = '0;
    logic [31:0] rec_crc   = CRC_INIT;
    logic [2:0]  rec_kind  = KIND_SUPER;
    int unsigned rec_pos   = 0;
    int unsigned rec_len   = 0;

    logic [31:0] sums_due [$];   // checksums predicted, oldest first
    logic [31:0] due_sum;
    int          mismatches   = 0;
    int          results_seen = 0;
    int          items_sent   = 0;
    int          cycle_count  = 0;

    bit          offering   = 0;  // sender currently holds tvalid high
    bit          idle_on    = 1;  // random gaps on both sides
    bit          hold_req   = 0;  // ask the receiver for one long hold-off
    int          hold_left  = 0;
    int          stall_left = 0;

    fs_metadata_crc32c dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // reflected CRC32C, one byte, polynomial applied by mask
    function automatic logic [31:0] crc32c_fold(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] v;
        v = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            v = (v >> 1) ^ (CRC_POLY & {32{v[0]}});
        end
        return v;
    endfunction

    // fold the low n bytes of v, least significant first
    function automatic logic [31:0] fold_le(input logic [31:0] c, input logic [63:0] v,
                                            input int n);
        logic [31:0] r;
        r = c;
        for (int i = 0; i < n; i++) begin
            r = crc32c_fold(r, v[8*i +: 8]);
        end
        return r;
    endfunction

    // Advances the predicted record state by one accepted byte.
    task automatic fold_record_byte(input rec_byte_t b, output bit emits,
                                    output logic [31:0] sum);
        logic [7:0]  d;
        bit          feed;
        int unsigned ln;
        d     = b.data;
        feed  = 1;
        emits = 0;
        sum   = '0;
        if (b.first) begin
            rec_kind = (b.kind > KIND_EXTENT) ? KIND_SUPER : b.kind;
            ln = b.len;
            if (ln == 0) ln = 1;
            if (ln > MAX_BYTES) ln = MAX_BYTES;
            rec_len = ln;
            rec_pos = 0;
            rec_crc = CRC_INIT;
            // prefix: UUID, then number, then generation, depending on kind
            if (rec_kind != KIND_SUPER) begin
                rec_crc = fold_le(rec_crc, uuid_lo_m, 8);
                rec_crc = fold_le(rec_crc, uuid_hi_m, 8);
            end
            if (rec_kind == KIND_GROUP || rec_kind == KIND_INODE ||
                rec_kind == KIND_DIR || rec_kind == KIND_EXTENT) begin
                rec_crc = fold_le(rec_crc, {32'd0, b.num}, 4);
            end
            if (rec_kind == KIND_INODE || rec_kind == KIND_DIR || rec_kind == KIND_EXTENT) begin
                rec_crc = fold_le(rec_crc, {32'd0, b.gen}, 4);
            end
        end else if (rec_pos >= rec_len) begin
            return;
        end
        case (rec_kind)
            KIND_GROUP: begin
                if (rec_pos == 30 || rec_pos == 31) d = 8'd0;
                else if (rec_pos >= 64) feed = 0;
            end
            KIND_INODE: begin
                if (rec_pos == 124 || rec_pos == 125 || rec_pos == 130 || rec_pos == 131)
                    d = 8'd0;
                else if (rec_pos >= 256) feed = 0;
            end
            KIND_DIR: begin
                feed = (rec_len > 12) && (rec_pos < rec_len - 12);
            end
            KIND_EXTENT: begin
                feed = rec_pos < rec_len - (rec_len % 12);
            end
            default: begin
            end
        endcase
        if (feed) rec_crc = crc32c_fold(rec_crc, d);
        rec_pos++;
        if (rec_pos >= rec_len) begin
            emits = 1;
            sum   = (rec_kind == KIND_GROUP) ? (rec_crc & GROUP_MASK) : rec_crc;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        if (mismatches < 50)
            $display("mismatch %s: expected %h got %h (cycle %0d)", what, want, got,
                     cycle_count);
        mismatches++;
    endtask

    // Lower tvalid (if offered), then sit idle for a span set by n.
    task automatic rest(input int n);
        if (offering) begin
            s_axis_tvalid <= 1'b0;
            offering = 0;
        end
        repeat (n) @(posedge i_clk);
    endtask

    // One input transaction; prediction taken at the accepting edge.
    task automatic push_byte(input rec_byte_t b, input logic known, input logic [31:0] typed);
        bit          emits;
        logic [31:0] sum;
        s_axis_tdata  <= {7'd0, b.gen, b.num, b.len, b.data};
        s_axis_tuser  <= {b.kind, b.first};
        s_axis_tvalid <= 1'b1;
        offering = 1;
        do @(posedge i_clk); while (!s_axis_tready);
        fold_record_byte(b, emits, sum);
        if (emits) sums_due.push_back(known ? typed : sum);
        if (idle_on && $urandom_range(0, 15) == 0) rest($urandom_range(1, 18));
    endtask

    function automatic rec_byte_t random_byte();
        rec_byte_t b;
        b.first = 1'b0;
        b.kind  = 3'($urandom_range(0, 7));
        b.len   = 17'($urandom_range(0, 131071));
        b.num   = $urandom;
        b.gen   = $urandom;
        b.data  = 8'($urandom_range(0, 255));
        return b;
    endfunction

    // First byte carries the header; later bytes carry junk in the header fields.
    task automatic send_record(input logic [2:0] kind, input logic [16:0] len,
                               input int nbytes);
        rec_byte_t b;
        for (int i = 0; i < nbytes; i++) begin
            b = random_byte();
            if (i == 0) begin
                b.first = 1'b1;
                b.kind  = kind;
                b.len   = len;
            end
            push_byte(b, 1'b0, '0);
        end
        items_sent += nbytes;
    endtask

    // Mostly short records; a few long enough to reach the inode and group cut-offs.
    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)  return 0;
        if (r < 64) return $urandom_range(1, 12);
        if (r < 88) return $urandom_range(13, 40);
        if (r < 96) return $urandom_range(124, 140);
        return $urandom_range(250, 300);
    endfunction

    task automatic send_random();
        int         shape;
        int         len;
        logic [2:0] kind;
        rec_byte_t  b;
        shape = $urandom_range(0, 99);
        kind  = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                            : 3'($urandom_range(0, 5));
        len   = pick_length();
        if (shape < 82) begin
            send_record(kind, 17'(len), (len == 0) ? 1 : len);
        end else if (shape < 92) begin
            // cut short; the next first byte abandons it
            if ($urandom_range(0, 3) == 0) len = 131071;
            if (len < 2) len = 2;
            send_record(kind, 17'(len), $urandom_range(1, (len > 301) ? 300 : len - 1));
        end else begin
            // stray bytes without a first flag
            repeat ($urandom_range(1, 3)) begin
                b = random_byte();
                push_byte(b, 1'b0, '0);
            end
        end
    endtask

    // Nothing in flight: all checksums back, then let any prefix run out.
    task automatic drain();
        rest(0);
        while (sums_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_uuid(input logic [63:0] lo, input logic [63:0] hi);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= REG_UUID_LOW;
        i_cfg_wdata <= lo;
        @(posedge i_clk);
        i_cfg_idx   <= REG_UUID_HIGH;
        i_cfg_wdata <= hi;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        uuid_lo_m = lo;
        uuid_hi_m = hi;
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (idle_on && $urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 18);
            end
        end
    end

    // Output checker and run limit.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            cycle_count++;
            if (cycle_count > LIMIT) begin
                $display("[fs_metadata_crc32c] ERROR");
                $finish;
            end else if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (sums_due.size() == 0) begin
                    report_mismatch("checksum with none due", 'x, m_axis_tdata);
                end else begin
                    due_sum = sums_due.pop_front();
                    if (m_axis_tdata !== due_sum) report_mismatch("checksum", due_sum, m_axis_tdata);
                end
            end
        end
    end

    initial begin
        int item_base;
        int result_base;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[r]) push_byte(DIRECTED[r].item, DIRECTED[r].known, DIRECTED[r].sum);

        // Four settings of the UUID; the last phase runs flat out with no gaps.
        for (int ph = 0; ph < 4; ph++) begin
            drain();
            case (ph)
                0: write_uuid('1, '1);
                1: write_uuid({$urandom, $urandom}, {$urandom, $urandom});
                2: write_uuid('0, {$urandom, $urandom});
                default: write_uuid({$urandom, $urandom}, '1);
            endcase
            idle_on     = (ph != 3);
            item_base   = items_sent;
            result_base = results_seen;
            if (ph == 1) begin
                // back-to-back one-byte records against a held output: input must stall
                hold_req = 1;
                repeat (8) send_record(KIND_SUPER, 17'd1, 1);
            end
            // longest length, past the group cut-off, then abandoned
            if (ph == 3) send_record(KIND_GROUP, 17'(MAX_BYTES), 70);
            while (items_sent - item_base < 50 || results_seen - result_base < 2)
                send_random();
            // close any abandoned record before the next register write
            send_record(KIND_BITMAP, 17'd4, 4);
        end

        drain();
        if (mismatches == 0)
            $display("[fs_metadata_crc32c] OK");
        else
            $display("[fs_metadata_crc32c] ERROR");
        $finish;
    end

endmodule
